// ===== rtl/nrpi_pkg.sv =====
package nrpi_pkg;

    // APB register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_RANGE_START = 1'b0;
    localparam logic [0:0] REG_RANGE_END   = 1'b1;

    // Item kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Field and datapath widths
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 8;
    localparam int RANGE_W = 9;
    localparam int SQ_W    = 2 * COLOR_W;
    localparam int DIST_W  = SQ_W + 2;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

endpackage

// ===== rtl/nearest_rgb_palette_index.sv =====
// nearest_rgb_palette_index
//
// Palette store plus nearest-color search. One input channel (s_*) carries
// two kinds of transfer: a write (s_action = 0) stores red/green/blue at
// s_entry_index and gives no result; a write past the palette is dropped.
// A query (s_action = 1) carries a target color and gives one result on the
// m_* channel: the first index in [range_start, range_end) with the smallest
// squared RGB distance, or range_start when that range (with range_end
// clamped to the palette size) is empty. The range registers sit on the APB
// port at byte addresses 0 and 4.
//
// Flow: a write is taken while idle and leaves the block idle. A query is
// answered once every entry of its range has been scanned (no entry is read
// when the range is empty); the single memory read port delivers one entry per
// cycle. s_ready is low from the query's acceptance until its result loads.
// When the receiver stalls, the result holds in the output register; new
// writes and the next query are still taken, and a query that finishes
// while the previous result still waits holds until it leaves.
// Reset clears control state and sets range_start = 0, range_end = 256.
// Palette contents are undefined until written; no clearing pass is run.
module nearest_rgb_palette_index #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [nrpi_pkg::INDEX_W-1:0]  s_entry_index,
    input  logic [nrpi_pkg::COLOR_W-1:0]  s_red,
    input  logic [nrpi_pkg::COLOR_W-1:0]  s_green,
    input  logic [nrpi_pkg::COLOR_W-1:0]  s_blue,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [nrpi_pkg::INDEX_W-1:0]  m_nearest_index,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nrpi_pkg::ADDR_W-1:0]   paddr,
    input  logic [nrpi_pkg::DATA_W-1:0]   pwdata,
    output logic [nrpi_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import nrpi_pkg::*;

    localparam int MEM_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Configuration
    logic [INDEX_W-1:0] range_start_reg;
    logic [RANGE_W-1:0] range_end_reg;
    logic               cfg_wr;
    logic [RANGE_W-1:0] end_clamped;
    logic               range_empty;

    // Control
    logic [1:0]         state_reg, state_next;
    logic [RANGE_W-1:0] scan_addr_reg;
    logic [RANGE_W-1:0] scan_end_reg;
    logic               scan_last;
    logic               s_xfer;
    logic               mem_wr;
    logic               issue;
    logic               load_out;

    // Palette memory and search pipeline
    rgb_t               palette_mem [PALETTE_ENTRIES];
    rgb_t               rd_data_reg;
    rgb_t               target_reg;
    logic               p1_valid_reg;
    logic [INDEX_W-1:0] p1_idx_reg;
    logic               p2_valid_reg;
    logic [INDEX_W-1:0] p2_idx_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [COLOR_W-1:0] diff_r, diff_g, diff_b;
    logic [DIST_W-1:0]  dist_sum;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [INDEX_W-1:0] best_idx_reg;

    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_index_reg;

    // ------------------------------------------------------------------
    // APB registers: write on the access phase, read combinationally.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg   <= RANGE_W'(256);
        end else if (cfg_wr) begin
            unique case (paddr[2:2])
                REG_RANGE_START: range_start_reg <= pwdata[INDEX_W-1:0];
                REG_RANGE_END:   range_end_reg   <= pwdata[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2:2])
            REG_RANGE_START: prdata = DATA_W'(range_start_reg);
            REG_RANGE_END:   prdata = DATA_W'(range_end_reg);
            default:         prdata = '0;
        endcase
    end

    // Clamp the end to the palette; an end at or below the start is empty.
    assign end_clamped = (range_end_reg > RANGE_W'(PALETTE_ENTRIES)) ?
                         RANGE_W'(PALETTE_ENTRIES) : range_end_reg;
    assign range_empty = end_clamped <= {1'b0, range_start_reg};

    // ------------------------------------------------------------------
    // Input side: writes go straight to memory, a query starts a scan.
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid & s_ready;
    assign mem_wr  = s_xfer && (s_action == ACT_WRITE) &&
                     ({1'b0, s_entry_index} < RANGE_W'(PALETTE_ENTRIES));
    assign issue     = (state_reg == ST_SCAN);
    assign scan_last = (RANGE_W'(scan_addr_reg + 1'b1) == scan_end_reg);
    assign load_out  = (state_reg == ST_DRAIN) && !p1_valid_reg && !p2_valid_reg &&
                       (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_action == ACT_QUERY) begin
                    state_next = range_empty ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Scan counter and captured query context
    always_ff @(posedge aclk) begin
        if (s_xfer && s_action == ACT_QUERY) begin
            scan_addr_reg <= {1'b0, range_start_reg};
            scan_end_reg  <= end_clamped;
            target_reg    <= '{red: s_red, green: s_green, blue: s_blue};
        end else if (issue) begin
            scan_addr_reg <= RANGE_W'(scan_addr_reg + 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Palette memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            palette_mem[s_entry_index[MEM_AW-1:0]] <=
                '{red: s_red, green: s_green, blue: s_blue};
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= palette_mem[scan_addr_reg[MEM_AW-1:0]];
    end

    // ------------------------------------------------------------------
    // Search pipeline: read, square, accumulate-and-compare.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    assign diff_r = (target_reg.red > rd_data_reg.red) ?
                    COLOR_W'(target_reg.red - rd_data_reg.red) :
                    COLOR_W'(rd_data_reg.red - target_reg.red);
    assign diff_g = (target_reg.green > rd_data_reg.green) ?
                    COLOR_W'(target_reg.green - rd_data_reg.green) :
                    COLOR_W'(rd_data_reg.green - target_reg.green);
    assign diff_b = (target_reg.blue > rd_data_reg.blue) ?
                    COLOR_W'(target_reg.blue - rd_data_reg.blue) :
                    COLOR_W'(rd_data_reg.blue - target_reg.blue);

    always_ff @(posedge aclk) begin
        p1_idx_reg <= scan_addr_reg[INDEX_W-1:0];
        p2_idx_reg <= p1_idx_reg;
        sq_r_reg   <= SQ_W'(diff_r * diff_r);
        sq_g_reg   <= SQ_W'(diff_g * diff_g);
        sq_b_reg   <= SQ_W'(diff_b * diff_b);
    end

    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    // Best starts above any real distance, so the first entry always wins;
    // strict less-than keeps the lowest index on ties.
    always_ff @(posedge aclk) begin
        if (s_xfer && s_action == ACT_QUERY) begin
            best_dist_reg <= '1;
            best_idx_reg  <= range_start_reg;
        end else if (p2_valid_reg && dist_sum < best_dist_reg) begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= p2_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold until the transfer, load when free.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_index_reg <= best_idx_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nearest_index = m_index_reg;

`ifndef SYNTHESIS
    a_pipe_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg || p2_valid_reg) |-> (state_reg != ST_IDLE))
        else $error("search pipeline active while idle");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_addr_reg < scan_end_reg))
        else $error("scan address past range end");

    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (best_idx_reg >= range_start_reg))
        else $error("result below range start");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_index_reg)))
        else $error("pending result lost");
`endif

endmodule

// ===== bench/nearest_palette_checker.sv =====
`timescale 1ns / 100ps

module nearest_palette_checker #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_action,
    input  logic [nrpi_pkg::INDEX_W-1:0]  s_entry_index,
    input  logic [nrpi_pkg::COLOR_W-1:0]  s_red,
    input  logic [nrpi_pkg::COLOR_W-1:0]  s_green,
    input  logic [nrpi_pkg::COLOR_W-1:0]  s_blue,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [nrpi_pkg::INDEX_W-1:0]  m_nearest_index,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [nrpi_pkg::ADDR_W-1:0]   paddr,
    input  logic [nrpi_pkg::DATA_W-1:0]   pwdata,

    output int                            mismatches,
    output int                            awaited
);
    import nrpi_pkg::*;

    rgb_t               palette_copy [PALETTE_ENTRIES];
    logic [INDEX_W-1:0] first_index;
    logic [RANGE_W-1:0] stop_index;
    logic [INDEX_W-1:0] nearest_expected [$];
    logic [INDEX_W-1:0] want;

    // First index in [first_index, stop) with the smallest squared distance.
    function automatic logic [INDEX_W-1:0] nearest_entry(input rgb_t target);
        int unsigned stop;
        int unsigned best_dist;
        int unsigned dist_sq;
        int unsigned i;
        int          dr;
        int          dg;
        int          db;
        logic [INDEX_W-1:0] best;
        stop      = (stop_index > PALETTE_ENTRIES) ? PALETTE_ENTRIES : stop_index;
        best      = first_index;
        best_dist = 32'h7FFF_FFFF;
        for (i = first_index; i < stop; i++) begin
            dr      = int'(target.red)   - int'(palette_copy[i].red);
            dg      = int'(target.green) - int'(palette_copy[i].green);
            db      = int'(target.blue)  - int'(palette_copy[i].blue);
            dist_sq = dr * dr + dg * dg + db * db;
            // strict compare: on a tie the lower index stays
            if (dist_sq < best_dist) begin
                best_dist = dist_sq;
                best      = INDEX_W'(i);
            end
        end
        return best;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            first_index = '0;
            stop_index  = RANGE_W'(256);
            nearest_expected.delete();
            mismatches = 0;
            awaited = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[ADDR_W-1:2] == REG_RANGE_START) begin
                    first_index = pwdata[INDEX_W-1:0];
                end else if (paddr[ADDR_W-1:2] == REG_RANGE_END) begin
                    stop_index = pwdata[RANGE_W-1:0];
                end
            end
            // retire results before queuing new queries
            if (m_valid && m_ready) begin
                if (nearest_expected.size() == 0) begin
                    $error("nearest_index: expected none, actual %0d", m_nearest_index);
                    mismatches++;
                end else begin
                    want = nearest_expected.pop_front();
                    if (m_nearest_index !== want) begin
                        $error("nearest_index: expected %0d, actual %0d", want,
                               m_nearest_index);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_action == ACT_WRITE) begin
                    if (s_entry_index < PALETTE_ENTRIES) begin
                        palette_copy[s_entry_index] = {s_red, s_green, s_blue};
                    end
                end else begin
                    nearest_expected.push_back(nearest_entry({s_red, s_green, s_blue}));
                end
            end
            awaited = nearest_expected.size();
        end
    end

endmodule

// ===== bench/tb_nearest_rgb_palette_index.sv =====
`timescale 1ns / 100ps

module tb_nearest_rgb_palette_index;
    import nrpi_pkg::*;

    localparam int ENTRIES         = 256;
    localparam int SETTLE_CYCLES   = 8;     // a write does not take the block out of idle
    localparam int STALL_LIMIT     = 3000;  // covers a full 256-entry scan plus gaps
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 30;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_action      = ACT_WRITE;
    logic [INDEX_W-1:0] s_entry_index = '0;
    logic [COLOR_W-1:0] s_red         = '0;
    logic [COLOR_W-1:0] s_green       = '0;
    logic [COLOR_W-1:0] s_blue        = '0;
    logic               m_ready       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]  pwdata        = '0;

    logic               s_ready;
    logic               m_valid;
    logic [INDEX_W-1:0] m_nearest_index;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Stimulus-side copy of the palette, used only to pick targets and ties.
    rgb_t shadow [ENTRIES];
    int   queries_sent  = 0;
    int   writes_sent   = 0;
    int   results_seen  = 0;
    int   settings_used = 0;
    int   idle_cycles   = 0;
    int   stall_left    = 0;
    bit   steady        = 1'b0;
    int   mismatches;
    int   awaited;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nearest_rgb_palette_index #(
        .PALETTE_ENTRIES(ENTRIES)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_entry_index   (s_entry_index),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_index (m_nearest_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    nearest_palette_checker #(
        .PALETTE_ENTRIES(ENTRIES)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_entry_index   (s_entry_index),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_index (m_nearest_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .awaited         (awaited)
    );

    // Result side: drop ready in random bursts unless the phase is steady.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!steady && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Count result transfers; the sender compares this with its query count.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic rgb_t random_color();
        return 24'($urandom());
    endfunction

    // Offer one transfer, maybe after a random gap, and hold it until accepted.
    // Valid stays high afterwards; the next call or settle() decides its fate.
    task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                             input rgb_t color);
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_entry_index <= idx;
        s_red         <= color.red;
        s_green       <= color.green;
        s_blue        <= color.blue;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (act == ACT_QUERY) begin
            queries_sent++;
        end else begin
            writes_sent++;
            shadow[idx] = color;
        end
    endtask

    // Stop sending and wait until every query has answered and the block is quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (results_seen != queries_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup and access cycles; the release is up to the caller.
    task automatic apb_setup(input logic [0:0] which, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    // Program both range registers back to back while the block is idle.
    task automatic set_range(input int lo, input int hi);
        settle();
        apb_setup(REG_RANGE_START, DATA_W'(lo));
        apb_setup(REG_RANGE_END, DATA_W'(hi));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int   phase;
        int   item;
        int   k;
        int   lo;
        int   hi;
        int   pick;
        rgb_t color;

        foreach (shadow[k]) shadow[k] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty range with both bounds at zero: answer is the start, no entry read.
        set_range(0, 0);
        send_item(ACT_QUERY, 8'h00, 24'h000000);
        send_item(ACT_QUERY, 8'hFF, 24'hFFFFFF);

        // Extremes and duplicates so ties resolve toward the lower index.
        send_item(ACT_WRITE, 8'd0, 24'h000000);
        send_item(ACT_WRITE, 8'd1, 24'hFFFFFF);
        send_item(ACT_WRITE, 8'd2, 24'hFF0000);
        send_item(ACT_WRITE, 8'd3, 24'h00FF00);
        send_item(ACT_WRITE, 8'd4, 24'h0000FF);
        send_item(ACT_WRITE, 8'd5, 24'hFFFFFF);
        send_item(ACT_WRITE, 8'd6, 24'h808080);
        send_item(ACT_WRITE, 8'd7, 24'h000000);
        send_item(ACT_WRITE, 8'd255, 24'hFF00FF);

        set_range(0, 8);
        send_item(ACT_QUERY, 8'h00, 24'h000000);
        send_item(ACT_QUERY, 8'hFF, 24'hFFFFFF);
        send_item(ACT_QUERY, 8'h33, 24'hFF0000);
        send_item(ACT_QUERY, 8'hCC, 24'h00FF00);
        send_item(ACT_QUERY, 8'h0F, 24'h0000FF);
        send_item(ACT_QUERY, 8'hF0, 24'h7F7F7F);
        send_item(ACT_QUERY, 8'h55, 24'hC8C8C8);

        // Single entry at the top of the palette.
        set_range(255, 256);
        send_item(ACT_QUERY, 8'h5A, 24'h000000);
        // End below start, then end equal to start: both empty.
        set_range(200, 100);
        send_item(ACT_QUERY, 8'($urandom()), random_color());
        set_range(8, 8);
        send_item(ACT_QUERY, 8'($urandom()), random_color());

        // Fill the whole palette; queries in between stay inside the written entries.
        set_range(0, 8);
        for (k = 0; k < ENTRIES; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_item(ACT_QUERY, 8'($urandom()), random_color());
            end
            if ($urandom_range(0, 3) == 0) begin
                color = shadow[$urandom_range(0, ENTRIES - 1)];
            end else begin
                color = random_color();
            end
            send_item(ACT_WRITE, INDEX_W'(k), color);
        end

        // Every entry is written now, so any range is legal.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    lo = 0;
                    hi = 256;
                end
                1: begin
                    lo = 0;
                    hi = 1;
                end
                2: begin
                    lo = 255;
                    hi = 256;
                end
                RANDOM_PHASES - 1: begin
                    lo = 0;
                    hi = 256;
                end
                default: begin
                    lo = $urandom_range(0, 255);
                    hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lo)
                                                     : $urandom_range(lo + 1, 256);
                end
            endcase
            set_range(lo, hi);
            // the last phase runs with no gaps and no stalls
            steady = (phase == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                if ($urandom_range(0, 39) == 0) begin
                    settle();
                end
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    if ($urandom_range(0, 3) == 0) begin
                        color = shadow[$urandom_range(0, ENTRIES - 1)];
                    end else begin
                        color = random_color();
                    end
                    send_item(ACT_WRITE, 8'($urandom()), color);
                end else begin
                    if (pick < 6 || hi <= lo) begin
                        color = random_color();
                    end else if (pick < 9) begin
                        // hit an entry inside the range exactly
                        color = shadow[$urandom_range(lo, hi - 1)];
                    end else begin
                        color.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        color.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        color.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                    send_item(ACT_QUERY, 8'($urandom()), color);
                end
            end
        end

        settle();
        $display("Covered %0d palette writes and %0d nearest-color queries over %0d range settings",
                 writes_sent, queries_sent, settings_used);
        $display("including empty, single-entry and full ranges, ties and stalls on both sides.");
        if (mismatches == 0 && awaited == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
